// File: src/mmd_pkg.sv
package mmd_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 4;
  localparam int unsigned NUM_CH       = 8;
  localparam int unsigned MAX_CH_DEF   = 8;
  localparam int unsigned RECIP_W      = 23;
  localparam int unsigned RECIP_SHIFT  = 22;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

  // fold modes
  localparam logic [1:0] MODE_AVERAGE   = 2'd0;
  localparam logic [1:0] MODE_AMBISONIC = 2'd1;
  localparam logic [1:0] MODE_FIVE_ONE  = 2'd2;

  localparam logic [3:0] COUNT_RESET = 4'd1;
  localparam logic [3:0] FOLD_DIV    = 4'd3;   // 98304 / 32768

  // 0.7071 in Q15
  localparam logic signed [15:0] ATTEN_Q15 = 16'sd23170;

  localparam logic [16:0] POS_LIMIT = 17'd32767;
  localparam logic [16:0] NEG_LIMIT = 17'd32768;
  localparam logic [15:0] SAT_POS   = 16'h7fff;
  localparam logic [15:0] SAT_NEG   = 16'h8000;

  // ceil(2^22 / d): exact floor(x / d) for x < 2^19 after >> 22
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd2:    r = 23'd2097152;
      4'd3:    r = 23'd1398102;
      4'd4:    r = 23'd1048576;
      4'd5:    r = 23'd838861;
      4'd6:    r = 23'd699051;
      4'd7:    r = 23'd599187;
      4'd8:    r = 23'd524288;
      default: r = 23'd4194304;
    endcase
    return r;
  endfunction

endpackage

// File: src/mmd_if.sv
interface mmd_frame_if;
  logic                                valid;
  logic                                ready;
  logic signed [mmd_pkg::SAMPLE_W-1:0] ch0;
  logic signed [mmd_pkg::SAMPLE_W-1:0] ch1;
  logic signed [mmd_pkg::SAMPLE_W-1:0] ch2;
  logic signed [mmd_pkg::SAMPLE_W-1:0] ch3;
  logic signed [mmd_pkg::SAMPLE_W-1:0] ch4;
  logic signed [mmd_pkg::SAMPLE_W-1:0] ch5;
  logic signed [mmd_pkg::SAMPLE_W-1:0] ch6;
  logic signed [mmd_pkg::SAMPLE_W-1:0] ch7;

  modport source (output valid, ch0, ch1, ch2, ch3, ch4, ch5, ch6, ch7, input ready);
  modport sink   (input valid, ch0, ch1, ch2, ch3, ch4, ch5, ch6, ch7, output ready);
endinterface

interface mmd_mono_if;
  logic                                valid;
  logic                                ready;
  logic signed [mmd_pkg::SAMPLE_W-1:0] mono_sample;
  logic                                clipped;

  modport source (output valid, mono_sample, clipped, input ready);
  modport sink   (input valid, mono_sample, clipped, output ready);
endinterface

interface mmd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mmd_pkg::CFG_IDX_W-1:0]      index;
  logic [mmd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/multichannel_mono_downmix.sv
// Throughput: one frame per cycle while mono_o.ready does not stall the
// pipeline, set by the six-register pipeline in which the shared reciprocal
// multiplier (mag x 23 bits) sits in its own stage.
// Back-pressure stalls only the stages that are full; bubbles collapse.
// Reset (rst_ni low, async) clears every stage valid bit and sets
// fold_mode to average and channel_count to 1.
module multichannel_mono_downmix #(
  parameter int unsigned MAX_CHANNELS = mmd_pkg::MAX_CH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmd_frame_if.sink   frame_i,
  mmd_cfg_if.sink     cfg_i,
  mmd_mono_if.source  mono_o
);

  localparam int unsigned NSTG = 6;

  // ---------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // ---------------------------------------------------------------
  logic [1:0] fold_mode_q;
  logic [3:0] channel_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_mode_q     <= mmd_pkg::MODE_AVERAGE;
      channel_count_q <= mmd_pkg::COUNT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mmd_pkg::REG_FOLD_MODE:     fold_mode_q     <= cfg_i.data[1:0];
        mmd_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_i.data[3:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or drains.
  // ---------------------------------------------------------------
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;
  logic            in_xfer;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || mono_o.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign frame_i.ready = en[0];
  assign in_xfer       = frame_i.valid && en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= frame_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: mode decode, masked channel sum, L+R and C+Ls+Rs.
  // Every fold ends in one signed divide: average by n, 5.1 by 3
  // (after >>15), pass-through by 1.
  // ---------------------------------------------------------------
  logic signed [15:0] ch [mmd_pkg::NUM_CH];
  logic [3:0]         n_clamp;
  logic [3:0]         eff_n;
  logic               fold_d;
  logic [3:0]         div_d;
  logic [18:0]        avg_d;
  logic [16:0]        lr_d;
  logic [17:0]        cs_d;

  assign ch[0] = frame_i.ch0;
  assign ch[1] = frame_i.ch1;
  assign ch[2] = frame_i.ch2;
  assign ch[3] = frame_i.ch3;
  assign ch[4] = frame_i.ch4;
  assign ch[5] = frame_i.ch5;
  assign ch[6] = frame_i.ch6;
  assign ch[7] = frame_i.ch7;

  always_comb begin
    if (channel_count_q == 4'd0) begin
      n_clamp = 4'd1;
    end else if (channel_count_q > 4'(MAX_CHANNELS)) begin
      n_clamp = 4'(MAX_CHANNELS);
    end else begin
      n_clamp = channel_count_q;
    end
    // ambisonic takes W only, same as a single channel average
    eff_n  = (fold_mode_q == mmd_pkg::MODE_AMBISONIC) ? 4'd1 : n_clamp;
    fold_d = (fold_mode_q == mmd_pkg::MODE_FIVE_ONE) && (n_clamp != 4'd1);
    div_d  = fold_d ? mmd_pkg::FOLD_DIV : eff_n;
  end

  always_comb begin
    avg_d = '0;
    for (int i = 0; i < mmd_pkg::NUM_CH; i++) begin
      if (4'(i) < eff_n) begin
        avg_d = avg_d + {{3{ch[i][15]}}, ch[i]};
      end
    end
  end

  assign lr_d = {ch[0][15], ch[0]} + {ch[1][15], ch[1]};
  assign cs_d = {{2{ch[2][15]}}, ch[2]} + {{2{ch[4][15]}}, ch[4]}
              + {{2{ch[5][15]}}, ch[5]};

  logic [18:0]        avg1_q;
  logic [16:0]        lr1_q;
  logic signed [17:0] cs1_q;
  logic               fold1_q;
  logic [3:0]         div1_q;

  // Stage 2: attenuate C+Ls+Rs by 0.7071 (18 x 16 signed)
  logic [18:0]        avg2_q;
  logic [16:0]        lr2_q;
  logic signed [32:0] prod2_q;
  logic               fold2_q;
  logic [3:0]         div2_q;
  logic signed [32:0] prod2_d;

  assign prod2_d = 33'(cs1_q) * 33'(mmd_pkg::ATTEN_Q15);

  // Stage 3: numerator 32768*(L+R) + 23170*(C+Ls+Rs), or the channel sum
  logic [34:0] val3_q;
  logic        fold3_q;
  logic [3:0]  div3_q;
  logic [34:0] val3_d;

  assign val3_d = fold2_q ?
      ({{3{lr2_q[16]}}, lr2_q, 15'd0} + {{2{prod2_q[32]}}, prod2_q}) :
      {{16{avg2_q[18]}}, avg2_q};

  // Stage 4: sign, magnitude and reciprocal lookup; 5.1 drops 15 bits (trunc composes)
  logic                        neg4_q;
  logic [18:0]                 mag4_q;
  logic [mmd_pkg::RECIP_W-1:0] recip4_q;
  logic [34:0]                 abs4;
  logic [18:0]                 mag4_d;

  assign abs4   = val3_q[34] ? (~val3_q + 35'd1) : val3_q;
  assign mag4_d = fold3_q ? abs4[33:15] : abs4[18:0];

  // Stage 5: reciprocal multiply
  logic        neg5_q;
  logic [38:0] prod5_q;
  logic [38:0] prod5_d;

  assign prod5_d = 39'(42'(mag4_q) * 42'(recip4_q));

  // Stage 6: quotient, sign, saturation
  logic [15:0] sample6_q;
  logic        clip6_q;
  logic [16:0] quo;
  logic [15:0] sample6_d;
  logic        clip6_d;

  assign quo = prod5_q[38:mmd_pkg::RECIP_SHIFT];

  always_comb begin
    clip6_d = 1'b0;
    if (neg5_q) begin
      if (quo > mmd_pkg::NEG_LIMIT) begin
        sample6_d = mmd_pkg::SAT_NEG;
        clip6_d   = 1'b1;
      end else begin
        sample6_d = 16'(~quo + 17'd1);
      end
    end else begin
      if (quo > mmd_pkg::POS_LIMIT) begin
        sample6_d = mmd_pkg::SAT_POS;
        clip6_d   = 1'b1;
      end else begin
        sample6_d = quo[15:0];
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      avg1_q  <= avg_d;
      lr1_q   <= lr_d;
      cs1_q   <= cs_d;
      fold1_q <= fold_d;
      div1_q  <= div_d;
    end
    if (en[1] && v_q[0]) begin
      avg2_q  <= avg1_q;
      lr2_q   <= lr1_q;
      prod2_q <= prod2_d;
      fold2_q <= fold1_q;
      div2_q  <= div1_q;
    end
    if (en[2] && v_q[1]) begin
      val3_q  <= val3_d;
      fold3_q <= fold2_q;
      div3_q  <= div2_q;
    end
    if (en[3] && v_q[2]) begin
      neg4_q   <= val3_q[34];
      mag4_q   <= mag4_d;
      recip4_q <= mmd_pkg::recip(div3_q);
    end
    if (en[4] && v_q[3]) begin
      neg5_q  <= neg4_q;
      prod5_q <= prod5_d;
    end
    if (en[5] && v_q[4]) begin
      sample6_q <= sample6_d;
      clip6_q   <= clip6_d;
    end
  end

  assign mono_o.valid       = v_q[NSTG-1];
  assign mono_o.mono_sample = sample6_q;
  assign mono_o.clipped     = clip6_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mono_o.valid && mono_o.clipped |->
      (sample6_q == mmd_pkg::SAT_POS) || (sample6_q == mmd_pkg::SAT_NEG))
    else $error("clip flag set on an unsaturated sample");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> v_q[0])
    else $error("accepted frame not held in first stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_i.ready |-> (&v_q) && !mono_o.ready)
    else $error("input stalled while the pipeline has a free slot");

endmodule

// File: dv/multichannel_mono_downmix_checker.sv
module multichannel_mono_downmix_checker #(
  parameter int unsigned MAX_CHANNELS = mmd_pkg::MAX_CH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mmd_frame_if frame_i,
  mmd_cfg_if   cfg_i,
  mmd_mono_if  mono_i,
  output int   mismatches_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [mmd_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [mmd_pkg::SAMPLE_W-1:0] mono_sample;
    logic                                clipped;
  } mono_t;

  localparam longint UNITY_Q15    = 32768;
  localparam longint FOLD_DIVISOR = 98304;
  localparam longint SAT_HI       = 32767;
  localparam longint SAT_LO       = -32768;

  logic [1:0] fold_mode_q;
  logic [3:0] channel_count_q;
  mono_t      expected_mono_q[$];

  function automatic mono_t fold_frame(input sample_t s [mmd_pkg::NUM_CH],
                                       input logic [1:0] mode,
                                       input logic [3:0] count);
    int     n;
    int     acc;
    longint num;
    longint q;
    mono_t  r;
    n = (count == 4'd0) ? 1 : int'(count);
    if (n > int'(MAX_CHANNELS)) n = int'(MAX_CHANNELS);
    r.clipped = 1'b0;
    if (n <= 1 || mode == mmd_pkg::MODE_AMBISONIC) begin
      r.mono_sample = s[0];
    end else if (mode == mmd_pkg::MODE_FIVE_ONE) begin
      // LFE (ch3) is dropped
      num = UNITY_Q15 * (longint'(s[0]) + longint'(s[1]))
          + longint'(mmd_pkg::ATTEN_Q15)
            * (longint'(s[2]) + longint'(s[4]) + longint'(s[5]));
      q = num / FOLD_DIVISOR;
      if (q > SAT_HI) begin
        q = SAT_HI;
        r.clipped = 1'b1;
      end else if (q < SAT_LO) begin
        q = SAT_LO;
        r.clipped = 1'b1;
      end
      r.mono_sample = q[mmd_pkg::SAMPLE_W-1:0];
    end else begin
      // average, also taken by the unused mode
      acc = 0;
      for (int i = 0; i < n; i++) acc += int'(s[i]);
      acc = acc / n;
      r.mono_sample = acc[mmd_pkg::SAMPLE_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s [mmd_pkg::NUM_CH];
    mono_t   got;
    mono_t   want;
    if (!rst_ni) begin
      fold_mode_q     = mmd_pkg::MODE_AVERAGE;
      channel_count_q = mmd_pkg::COUNT_RESET;
      expected_mono_q.delete();
      mismatches_o    = 0;
      pending_o       = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          mmd_pkg::REG_FOLD_MODE:     fold_mode_q = cfg_i.data[1:0];
          mmd_pkg::REG_CHANNEL_COUNT: channel_count_q = cfg_i.data;
          default: ;
        endcase
      end
      // results leave before new frames enter: every frame is registered before it reaches mono_o
      if (mono_i.valid && mono_i.ready) begin
        got.mono_sample = mono_i.mono_sample;
        got.clipped     = mono_i.clipped;
        if (expected_mono_q.size() == 0) begin
          $display("%0t: expected none, actual mono_sample %0d clipped %0d",
                   $time, got.mono_sample, got.clipped);
          mismatches_o++;
        end else begin
          want = expected_mono_q.pop_front();
          if (got.mono_sample !== want.mono_sample) begin
            $display("%0t: mono_sample expected %0d actual %0d",
                     $time, want.mono_sample, got.mono_sample);
            mismatches_o++;
          end
          if (got.clipped !== want.clipped) begin
            $display("%0t: clipped expected %0d actual %0d", $time, want.clipped, got.clipped);
            mismatches_o++;
          end
        end
      end
      if (frame_i.valid && frame_i.ready) begin
        s[0] = frame_i.ch0;
        s[1] = frame_i.ch1;
        s[2] = frame_i.ch2;
        s[3] = frame_i.ch3;
        s[4] = frame_i.ch4;
        s[5] = frame_i.ch5;
        s[6] = frame_i.ch6;
        s[7] = frame_i.ch7;
        expected_mono_q = {expected_mono_q, fold_frame(s, fold_mode_q, channel_count_q)};
      end
      pending_o = expected_mono_q.size();
    end
  end

endmodule

// File: dv/multichannel_mono_downmix_tb.sv
module multichannel_mono_downmix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [mmd_pkg::SAMPLE_W-1:0] sample_t;
  typedef sample_t frame_t [mmd_pkg::NUM_CH];

  // Slowest legal run is roughly 1700 frames, each with its largest gap and stall
  // and the pipe, plus one long hold and per-phase drains; this is many times that.
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned PHASES         = 30;
  localparam int unsigned PHASE_FRAMES   = 55;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PRESSURE_PHASE = 5;
  localparam int unsigned DRAIN_CYCLES   = 10;  // pipe is 6 deep

  // indexes past the register list: writes must be dropped
  localparam logic [mmd_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [mmd_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  // unused fold mode, folds like average
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam sample_t S_MAX = 16'sh7fff;
  localparam sample_t S_MIN = 16'sh8000;

  // first random phases walk the corner settings, later ones are drawn
  localparam logic [1:0] CORNER_MODE [8] = '{
    mmd_pkg::MODE_AVERAGE, mmd_pkg::MODE_AVERAGE, mmd_pkg::MODE_FIVE_ONE,
    mmd_pkg::MODE_AMBISONIC, MODE_SPARE, mmd_pkg::MODE_AVERAGE,
    mmd_pkg::MODE_FIVE_ONE, mmd_pkg::MODE_AVERAGE};
  localparam logic [3:0] CORNER_COUNT [8] = '{4'd8, 4'd1, 4'd6, 4'd8, 4'd5, 4'd0, 4'd15, 4'd9};

  logic        clk = 1'b0;
  logic        rst_n;
  int          mismatches;
  int          pending;
  int          hold_len = 0;
  bit          src_idle;
  bit          sink_idle;
  int          n_sent = 0;
  int          n_settings = 0;
  int unsigned cycles = 0;

  mmd_frame_if frame_if ();
  mmd_cfg_if   cfg_if ();
  mmd_mono_if  mono_if ();

  multichannel_mono_downmix dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .frame_i(frame_if),
    .cfg_i  (cfg_if),
    .mono_o (mono_if)
  );

  multichannel_mono_downmix_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .frame_i     (frame_if),
    .cfg_i       (cfg_if),
    .mono_i      (mono_if),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("multichannel_mono_downmix test failed");
      $finish;
    end
  end

  function automatic frame_t flat(input sample_t v);
    frame_t f;
    for (int i = 0; i < mmd_pkg::NUM_CH; i++) f[i] = v;
    return f;
  endfunction

  // Mix of uniform frames (every bit toggles), corner values, and frames of
  // large same-sign samples that push the 5.1 fold into saturation.
  task automatic rand_frame(output frame_t f);
    int style;
    bit neg;
    style = $urandom_range(0, 9);
    neg   = $urandom_range(0, 1);
    for (int i = 0; i < mmd_pkg::NUM_CH; i++) begin
      case (style)
        0, 1: begin
          case ($urandom_range(0, 4))
            0:       f[i] = S_MAX;
            1:       f[i] = S_MIN;
            2:       f[i] = '0;
            3:       f[i] = '1;
            default: f[i] = sample_t'(1);
          endcase
        end
        2, 3: begin
          f[i] = neg ? sample_t'(-int'($urandom_range(12000, 32768)))
                     : sample_t'($urandom_range(12000, 32767));
        end
        default: f[i] = sample_t'($urandom);
      endcase
    end
  endtask

  // One frame transfer. Valid is lowered only when a gap is drawn, so it never
  // drops and rises in the same step between back-to-back frames.
  task automatic send_frame(input frame_t f);
    int gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_if.valid <= 1'b1;
    frame_if.ch0   <= f[0];
    frame_if.ch1   <= f[1];
    frame_if.ch2   <= f[2];
    frame_if.ch3   <= f[3];
    frame_if.ch4   <= f[4];
    frame_if.ch5   <= f[5];
    frame_if.ch6   <= f[6];
    frame_if.ch7   <= f[7];
    do @(posedge clk); while (!frame_if.ready);
    n_sent++;
  endtask

  // Stop offering frames and wait for the pipe to empty before any register
  // write; every frame yields a result, so pending == 0 means idle.
  task automatic settle();
    @(negedge clk);
    frame_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [mmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mmd_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] mode, input logic [3:0] count);
    settle();
    cfg_write(mmd_pkg::REG_FOLD_MODE, {2'b00, mode});
    cfg_write(mmd_pkg::REG_CHANNEL_COUNT, count);
    n_settings++;
  endtask

  // Result side: draws a stall per result; a pending hold request replaces
  // the draw once and keeps ready low for the whole hold.
  initial begin : mono_sink
    int stall;
    mono_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = sink_idle ? $urandom_range(0, 5) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        mono_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      mono_if.ready <= 1'b1;
      do @(posedge clk); while (!(mono_if.valid && mono_if.ready));
    end
  end

  initial begin : stimulus
    frame_t     f;
    logic [3:0] count_d;

    frame_if.valid = 1'b0;
    frame_if.ch0   = '0;
    frame_if.ch1   = '0;
    frame_if.ch2   = '0;
    frame_if.ch3   = '0;
    frame_if.ch4   = '0;
    frame_if.ch5   = '0;
    frame_if.ch6   = '0;
    frame_if.ch7   = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    src_idle       = 1'b1;
    sink_idle      = 1'b1;
    rst_n          = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    // reset settings: single channel, ch0 passes through
    send_frame(flat(S_MAX));
    f = flat('0);
    f[0] = S_MIN;
    send_frame(f);

    // full-width average: rails, -1, and a small negative sum truncated to 0
    configure(mmd_pkg::MODE_AVERAGE, 4'd8);
    send_frame(flat(S_MAX));
    send_frame(flat(S_MIN));
    send_frame(flat('1));
    f = flat('0);
    f[0] = sample_t'(-3);
    f[1] = sample_t'(1);
    send_frame(f);

    // odd divisor, channels past the count must not leak in
    configure(mmd_pkg::MODE_AVERAGE, 4'd3);
    f = flat(S_MAX);
    f[2] = '1;
    send_frame(f);
    f = flat(S_MIN);
    f[0] = S_MAX;
    send_frame(f);

    // ambisonic ignores the count and takes W
    configure(mmd_pkg::MODE_AMBISONIC, 4'd8);
    f = flat(S_MAX);
    f[0] = S_MIN;
    send_frame(f);

    // 5.1: clip high, clip low, zero, LFE-only content, a small exact negative result
    configure(mmd_pkg::MODE_FIVE_ONE, 4'd6);
    send_frame(flat(S_MAX));
    send_frame(flat(S_MIN));
    send_frame(flat('0));
    f = flat('0);
    f[3] = S_MAX;
    send_frame(f);
    f = flat('0);
    f[0] = sample_t'(-5);
    f[1] = sample_t'(2);
    send_frame(f);

    // unused mode folds as average
    configure(MODE_SPARE, 4'd7);
    rand_frame(f);
    send_frame(f);

    // count of one, and zero treated as one, beat the 5.1 fold
    configure(mmd_pkg::MODE_FIVE_ONE, 4'd1);
    send_frame(flat(S_MAX));
    configure(mmd_pkg::MODE_FIVE_ONE, 4'd0);
    send_frame(flat(S_MIN));

    // count above the channel limit saturates to eight
    configure(mmd_pkg::MODE_AVERAGE, 4'd15);
    rand_frame(f);
    send_frame(f);

    // --- random phases ---
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if ($urandom_range(0, 3) == 0)
        cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 4'($urandom));
      if (p < 8) begin
        cfg_write(mmd_pkg::REG_FOLD_MODE, {2'b00, CORNER_MODE[p]});
        cfg_write(mmd_pkg::REG_CHANNEL_COUNT, CORNER_COUNT[p]);
      end else begin
        // upper data bits of the mode write are dropped by the block
        count_d = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        cfg_write(mmd_pkg::REG_FOLD_MODE, 4'($urandom));
        cfg_write(mmd_pkg::REG_CHANNEL_COUNT, count_d);
      end
      n_settings++;

      // every fourth phase runs flat out on both sides
      src_idle  = (p % 4 != 3) && ($urandom_range(0, 3) != 0);
      sink_idle = (p % 4 != 3) && ($urandom_range(0, 3) != 0);
      if (p == PRESSURE_PHASE) begin
        // long output hold while frames keep coming: pipe fills, input stalls
        src_idle = 1'b0;
        hold_len = HOLD_CYCLES;
      end

      repeat (PHASE_FRAMES) begin
        rand_frame(f);
        send_frame(f);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d frames under %0d register settings: fold modes 0-3, counts 0-15,",
             n_sent, n_settings);
    $display("saturating 5.1 frames, random gaps on both sides and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("multichannel_mono_downmix test passed");
    end else begin
      $display("multichannel_mono_downmix test failed");
    end
    $finish;
  end

endmodule
